FILE: sv/zero_padded_vector_alu_defines.svh
// Assertion helpers for the vector ALU. Both expect clk_i and rst_ni in scope.
`ifndef ZERO_PADDED_VECTOR_ALU_DEFINES_SVH
`define ZERO_PADDED_VECTOR_ALU_DEFINES_SVH

// Same-cycle implication.
`define ZPVA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zpva assertion failed");

// Next-cycle implication.
`define ZPVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zpva assertion failed");

`endif

FILE: sv/zpva_pkg.sv
`timescale 1ns / 1ps

package zpva_pkg;

  localparam int unsigned ACC_WIDTH = 64;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_DOT   = 3'd2,
    KIND_SCALE = 3'd3,
    KIND_CMP   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ORDER_EQ = 2'd0,
    ORDER_LT = 2'd1,
    ORDER_GT = 2'd2
  } order_e;

  // Control of the item leaving the product stage.
  typedef struct packed {
    logic  fire;  // item leaves the product stage this cycle
    kind_e kind;
    logic  last;
    logic  lt;    // a < b
    logic  gt;    // a > b
  } s2_ctrl_t;

endpackage

FILE: sv/zero_padded_vector_alu.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    kind_i a_elem_i b_elem_i a_present_i b_present_i
//                                      scalar_i last_i
// output    out_valid_o / out_ready_i  value_o order_o last_out_o
//
// One item per cycle sustained while the output is not stalled; a result becomes valid
// once its item has passed the input register, which loads at the transfer, then the
// multiplier stage, then the accumulate/saturate stage into the output register.
// Dot and compare items before the last position leave no result.
// rst_ni clears all valid flags, the dot accumulator and the compare verdict.
// Each stage holds only while the stage after it is full and stalled, so up to two
// new items still enter while a finished result waits at the output.

module zero_padded_vector_alu
  import zpva_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    kind_i,
  input  logic signed [VALUE_WIDTH-1:0] a_elem_i,
  input  logic signed [VALUE_WIDTH-1:0] b_elem_i,
  input  logic                          a_present_i,
  input  logic                          b_present_i,
  input  logic signed [VALUE_WIDTH-1:0] scalar_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic [1:0]                    order_o,
  output logic                          last_out_o
);

  localparam int unsigned W = VALUE_WIDTH;
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // Stage 1: input register
  logic                v1_q;
  kind_e               kind1_q;
  logic signed [W-1:0] a1_q, b1_q, s1_q;
  logic                last1_q;
  logic                kind_ok;

  // Stage 2: product and sum
  logic                  v2_q;
  kind_e                 kind2_q;
  logic                  last2_q, lt2_q, gt2_q;
  logic signed [2*W-1:0] prod2_q, prod2_d;
  logic signed [W-1:0]   sum2_q, sum2_d;
  logic signed [W-1:0]   mul_op;
  logic [W:0]            sum_wide;

  // Output register
  logic         out_valid_q;
  logic [W-1:0] value_q;
  order_e       order_q;
  logic         last_q;

  logic         r_out, r2;
  s2_ctrl_t     ctrl;
  logic         res_valid;
  logic [W-1:0] res_value;
  order_e       res_order;

  assign r_out      = !out_valid_q || out_ready_i;
  assign r2         = !v2_q || r_out;
  assign in_ready_o = !v1_q || r2;

  assign kind_ok = (kind_i == KIND_ADD) || (kind_i == KIND_SUB) || (kind_i == KIND_DOT)
                || (kind_i == KIND_SCALE) || (kind_i == KIND_CMP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      // unused kinds are taken and dropped here
      v1_q <= in_valid_i && kind_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      kind1_q <= kind_e'(kind_i);
      a1_q    <= a_present_i ? a_elem_i : '0;
      b1_q    <= b_present_i ? b_elem_i : '0;
      s1_q    <= scalar_i;
      last1_q <= last_i;
    end
  end

  assign mul_op  = (kind1_q == KIND_SCALE) ? s1_q : a1_q;
  assign prod2_d = mul_op * b1_q;

  assign sum_wide = (kind1_q == KIND_SUB) ? ({a1_q[W-1], a1_q} - {b1_q[W-1], b1_q})
                                          : ({a1_q[W-1], a1_q} + {b1_q[W-1], b1_q});

  always_comb begin
    if (sum_wide[W] != sum_wide[W-1]) begin
      sum2_d = sum_wide[W] ? MIN_V : MAX_V;
    end else begin
      sum2_d = sum_wide[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (r2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2) begin
      kind2_q <= kind1_q;
      last2_q <= last1_q;
      lt2_q   <= a1_q < b1_q;
      gt2_q   <= a1_q > b1_q;
      prod2_q <= prod2_d;
      sum2_q  <= sum2_d;
    end
  end

  assign ctrl.fire = v2_q && r_out;
  assign ctrl.kind = kind2_q;
  assign ctrl.last = last2_q;
  assign ctrl.lt   = lt2_q;
  assign ctrl.gt   = gt2_q;

  zpva_reduce #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .prod_i      (prod2_q),
    .sum_i       (sum2_q),
    .res_valid_o (res_valid),
    .res_value_o (res_value),
    .res_order_o (res_order)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (r_out) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_out) begin
      value_q <= res_value;
      order_q <= res_order;
      last_q  <= last2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign order_o     = order_q;
  assign last_out_o  = last_q;

endmodule

FILE: sv/zpva_reduce.sv
`timescale 1ns / 1ps
`include "zero_padded_vector_alu_defines.svh"

module zpva_reduce
  import zpva_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  s2_ctrl_t                      ctrl_i,
  input  logic signed [2*VALUE_WIDTH-1:0] prod_i,
  input  logic signed [VALUE_WIDTH-1:0] sum_i,
  output logic                          res_valid_o,
  output logic [VALUE_WIDTH-1:0]        res_value_o,
  output order_e                        res_order_o
);

  localparam int unsigned W = VALUE_WIDTH;
  localparam int unsigned P = 2 * VALUE_WIDTH;
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH-1:0] acc_q, acc_d, acc_sum;
  order_e                      verdict_q, verdict_d, verdict_upd;
  logic signed [P-1:0]         prod_sh;
  logic [W-1:0]                prod_sat, acc_sat;
  logic [ACC_WIDTH:0]          acc_wide;
  logic                        dot_done, cmp_done, cmp_held, kind_unused;

  // Arithmetic shift floors toward minus infinity.
  assign prod_sh = prod_i >>> FRAC_BITS;

  always_comb begin
    if ((&prod_sh[P-1:W-1]) || !(|prod_sh[P-1:W-1])) begin
      prod_sat = prod_sh[W-1:0];
    end else begin
      prod_sat = prod_sh[P-1] ? MIN_V : MAX_V;
    end
  end

  assign acc_wide = {acc_q[ACC_WIDTH-1], acc_q}
                  + {{(ACC_WIDTH-W+1){prod_sat[W-1]}}, prod_sat};

  always_comb begin
    if (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1]) begin
      acc_sum = acc_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sum = acc_wide[ACC_WIDTH-1:0];
    end
  end

  always_comb begin
    if ((&acc_sum[ACC_WIDTH-1:W-1]) || !(|acc_sum[ACC_WIDTH-1:W-1])) begin
      acc_sat = acc_sum[W-1:0];
    end else begin
      acc_sat = acc_sum[ACC_WIDTH-1] ? MIN_V : MAX_V;
    end
  end

  // First unequal pair decides.
  always_comb begin
    verdict_upd = verdict_q;
    if (verdict_q == ORDER_EQ) begin
      if (ctrl_i.lt) begin
        verdict_upd = ORDER_LT;
      end else if (ctrl_i.gt) begin
        verdict_upd = ORDER_GT;
      end
    end
  end

  always_comb begin
    acc_d       = acc_q;
    verdict_d   = verdict_q;
    res_valid_o = 1'b0;
    res_value_o = '0;
    res_order_o = ORDER_EQ;
    unique case (ctrl_i.kind)
      KIND_ADD, KIND_SUB: begin
        res_valid_o = ctrl_i.fire;
        res_value_o = sum_i;
      end
      KIND_SCALE: begin
        res_valid_o = ctrl_i.fire;
        res_value_o = prod_sat;
      end
      KIND_DOT: begin
        res_valid_o = ctrl_i.fire && ctrl_i.last;
        res_value_o = acc_sat;
        if (ctrl_i.fire) begin
          acc_d = ctrl_i.last ? '0 : acc_sum;
        end
      end
      KIND_CMP: begin
        res_valid_o = ctrl_i.fire && ctrl_i.last;
        res_order_o = verdict_upd;
        if (ctrl_i.fire) begin
          verdict_d = ctrl_i.last ? ORDER_EQ : verdict_upd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      verdict_q <= ORDER_EQ;
    end else begin
      acc_q     <= acc_d;
      verdict_q <= verdict_d;
    end
  end

  assign dot_done    = ctrl_i.fire && ctrl_i.kind == KIND_DOT && ctrl_i.last;
  assign cmp_done    = ctrl_i.fire && ctrl_i.kind == KIND_CMP && ctrl_i.last;
  assign cmp_held    = ctrl_i.fire && ctrl_i.kind == KIND_CMP && !ctrl_i.last
                    && verdict_q != ORDER_EQ;
  assign kind_unused = ctrl_i.kind != KIND_ADD && ctrl_i.kind != KIND_SUB
                    && ctrl_i.kind != KIND_DOT && ctrl_i.kind != KIND_SCALE
                    && ctrl_i.kind != KIND_CMP;

  `ZPVA_ASSERT_NEXT(a_acc_clear, dot_done, acc_q == '0)
  `ZPVA_ASSERT_NEXT(a_verdict_clear, cmp_done, verdict_q == ORDER_EQ)
  `ZPVA_ASSERT_NEXT(a_verdict_sticky, cmp_held, $stable(verdict_q))
  `ZPVA_ASSERT(a_no_result_unused, kind_unused, !res_valid_o)

endmodule

FILE: tb/sv/zero_padded_vector_alu_checker.sv
`timescale 1ns / 1ps

module zero_padded_vector_alu_checker
  import zpva_pkg::*;
#(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [2:0]          kind_i,
  input  logic signed [W-1:0] a_elem_i,
  input  logic signed [W-1:0] b_elem_i,
  input  logic                a_present_i,
  input  logic                b_present_i,
  input  logic signed [W-1:0] scalar_i,
  input  logic                last_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic signed [W-1:0] value_i,
  input  logic [1:0]          order_i,
  input  logic                last_out_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned WIDE = ((2 * W > ACC_WIDTH) ? 2 * W : ACC_WIDTH) + 2;

  typedef struct {
    logic signed [W-1:0] value;
    order_e              order;
    logic                last;
  } alu_result_t;

  alu_result_t                 result_q[$];
  logic signed [ACC_WIDTH-1:0] dot_sum;
  order_e                      cmp_verdict;
  int unsigned                 err_cnt;

  function automatic logic signed [W-1:0] sat_value(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] hi;
    logic signed [WIDE-1:0] lo;
    hi = 1;
    hi = (hi <<< (W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[W-1:0];
    if (v < lo) return lo[W-1:0];
    return v[W-1:0];
  endfunction

  // Exact product, arithmetic shift floors the dropped fraction.
  function automatic logic signed [W-1:0] fx_product(input logic signed [W-1:0] x,
                                                      input logic signed [W-1:0] y);
    logic signed [2*W-1:0] xe;
    logic signed [2*W-1:0] ye;
    logic signed [2*W-1:0] prod;
    xe = x;
    ye = y;
    prod = xe * ye;
    prod = prod >>> F;
    return sat_value(prod);
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc_add(
      input logic signed [ACC_WIDTH-1:0] acc, input logic signed [W-1:0] p);
    logic signed [ACC_WIDTH+1:0] sum;
    logic signed [ACC_WIDTH+1:0] hi;
    logic signed [ACC_WIDTH+1:0] lo;
    sum = acc + p;
    hi = {3'b000, {(ACC_WIDTH-1){1'b1}}};
    lo = {3'b111, {(ACC_WIDTH-1){1'b0}}};
    if (sum > hi) return hi[ACC_WIDTH-1:0];
    if (sum < lo) return lo[ACC_WIDTH-1:0];
    return sum[ACC_WIDTH-1:0];
  endfunction

  task automatic predict_elem();
    logic signed [W-1:0]    a;
    logic signed [W-1:0]    b;
    logic signed [WIDE-1:0] wide;
    alu_result_t            r;
    a = a_present_i ? a_elem_i : '0;
    b = b_present_i ? b_elem_i : '0;
    r.value = '0;
    r.order = ORDER_EQ;
    r.last  = last_i;
    case (kind_i)
      KIND_ADD: begin
        wide = a + b;
        r.value = sat_value(wide);
        result_q.push_back(r);
      end
      KIND_SUB: begin
        wide = a - b;
        r.value = sat_value(wide);
        result_q.push_back(r);
      end
      KIND_SCALE: begin
        r.value = fx_product(scalar_i, b);
        result_q.push_back(r);
      end
      KIND_DOT: begin
        dot_sum = sat_acc_add(dot_sum, fx_product(a, b));
        if (last_i) begin
          r.value = sat_value(dot_sum);
          r.last  = 1'b1;
          result_q.push_back(r);
          dot_sum = '0;
        end
      end
      KIND_CMP: begin
        // first unequal position decides
        if (cmp_verdict == ORDER_EQ) begin
          if (a < b) cmp_verdict = ORDER_LT;
          else if (a > b) cmp_verdict = ORDER_GT;
        end
        if (last_i) begin
          r.order = cmp_verdict;
          r.last  = 1'b1;
          result_q.push_back(r);
          cmp_verdict = ORDER_EQ;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    alu_result_t exp_r;
    if (result_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= REPORT_LIMIT)
        $display("unexpected result: value %h order %0d last %0d",
                 value_i, order_i, last_out_i);
    end else begin
      exp_r = result_q.pop_front();
      if (value_i !== exp_r.value || order_i !== exp_r.order ||
          last_out_i !== exp_r.last) begin
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT)
          $display("mismatch (exp/got): value %h/%h order %0d/%0d last %0d/%0d",
                   exp_r.value, value_i, exp_r.order, order_i, exp_r.last, last_out_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q.delete();
      dot_sum = '0;
      cmp_verdict = ORDER_EQ;
      err_cnt = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      // a result never comes from the transfer at the same edge
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_elem();
      errors_o <= err_cnt;
      pending_o <= result_q.size();
    end
  end

endmodule

FILE: tb/sv/zero_padded_vector_alu_tb.sv
`timescale 1ns / 1ps

module zero_padded_vector_alu_tb;
  import zpva_pkg::*;

  localparam int unsigned W = 32;
  localparam int unsigned F = 16;
  localparam int unsigned ITEM_COUNT = 1250;
  localparam int unsigned PHASE_COUNT = 4;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned KIND_CODE_MAX = 7;
  localparam int unsigned MAX_LEN = 6;

  localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] VAL_ONE = 1 << F;
  localparam logic signed [W-1:0] VAL_LSB = 1;
  localparam logic signed [W-1:0] VAL_NEG_LSB = -1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [2:0]          kind_i = KIND_ADD;
  logic signed [W-1:0] a_elem_i = '0;
  logic signed [W-1:0] b_elem_i = '0;
  logic                a_present_i = 1'b0;
  logic                b_present_i = 1'b0;
  logic signed [W-1:0] scalar_i = '0;
  logic                last_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [W-1:0] value_o;
  logic [1:0]          order_o;
  logic                last_out_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned elems_sent = 0;

  zero_padded_vector_alu #(
    .VALUE_WIDTH(W),
    .FRAC_BITS  (F)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .a_elem_i   (a_elem_i),
    .b_elem_i   (b_elem_i),
    .a_present_i(a_present_i),
    .b_present_i(b_present_i),
    .scalar_i   (scalar_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .order_o    (order_o),
    .last_out_o (last_out_o)
  );

  zero_padded_vector_alu_checker #(
    .W(W),
    .F(F)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .kind_i     (kind_i),
    .a_elem_i   (a_elem_i),
    .b_elem_i   (b_elem_i),
    .a_present_i(a_present_i),
    .b_present_i(b_present_i),
    .scalar_i   (scalar_i),
    .last_i     (last_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_i    (value_o),
    .order_i    (order_o),
    .last_out_i (last_out_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  // Q16.16 values: extremes, small magnitudes and full-range noise
  function automatic logic signed [W-1:0] random_q16();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return VAL_NEG_LSB;
      4: return ($urandom_range(1) != 0) ? VAL_ONE : -VAL_ONE;
      5, 6: return $urandom;
      default: return $signed($urandom_range(1 << (F + 4))) - (1 << (F + 3));
    endcase
  endfunction

  task automatic send_elem(input logic [2:0] kind, input logic signed [W-1:0] a,
                           input logic signed [W-1:0] b, input logic ap, input logic bp,
                           input logic signed [W-1:0] s, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    a_elem_i    <= a;
    b_elem_i    <= b;
    a_present_i <= ap;
    b_present_i <= bp;
    scalar_i    <= s;
    last_i      <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (kind <= KIND_CMP) elems_sent++;
  endtask

  // one whole vector pair; the shorter one is padded with absent elements
  task automatic send_vector(input logic [2:0] kind);
    int unsigned         len_a;
    int unsigned         len_b;
    int unsigned         n;
    logic signed [W-1:0] s;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    len_a = $urandom_range(MAX_LEN);
    len_b = ($urandom_range(1) != 0) ? len_a : $urandom_range(MAX_LEN);
    n = (len_a > len_b) ? len_a : len_b;
    if (n == 0) n = 1;
    s = random_q16();
    for (int unsigned i = 0; i < n; i++) begin
      a = random_q16();
      b = (kind == KIND_CMP && $urandom_range(9) < 7) ? a : random_q16();
      send_elem(kind, a, b, i < len_a, i < len_b, s, i == n - 1);
    end
  endtask

  initial begin
    int unsigned target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_elem(KIND_ADD, VAL_MAX, VAL_MAX, 1, 1, '0, 0);
    send_elem(KIND_SUB, VAL_MIN, VAL_MAX, 1, 1, VAL_MAX, 1);
    send_elem(KIND_ADD, VAL_MIN, VAL_MAX, 1, 0, VAL_MIN, 0);
    send_elem(KIND_SUB, VAL_MAX, VAL_MIN, 0, 1, '0, 1);
    send_elem(KIND_SCALE, VAL_MAX, VAL_MIN, 1, 1, VAL_MIN, 0);
    send_elem(KIND_SCALE, '0, VAL_MAX, 0, 1, VAL_MIN, 0);
    send_elem(KIND_SCALE, '0, VAL_NEG_LSB, 1, 1, VAL_LSB, 0);
    send_elem(KIND_SCALE, VAL_MAX, VAL_MIN, 1, 0, VAL_MAX, 1);
    send_elem(KIND_DOT, VAL_MAX, VAL_MAX, 1, 1, '0, 0);
    send_elem(KIND_DOT, VAL_MIN, VAL_MIN, 1, 1, '0, 1);
    // floor of a tiny negative product, then an add in the middle of the dot
    send_elem(KIND_DOT, VAL_NEG_LSB, VAL_LSB, 1, 1, '0, 0);
    send_elem(KIND_ADD, VAL_ONE, VAL_ONE, 1, 1, '0, 1);
    send_elem(KIND_DOT, VAL_ONE, VAL_MAX, 0, 1, '0, 1);
    send_elem(KIND_CMP, VAL_ONE, VAL_ONE, 1, 1, '0, 0);
    send_elem(KIND_CMP, VAL_MAX, VAL_MIN, 0, 1, '0, 0);
    send_elem(KIND_CMP, VAL_MIN, VAL_MAX, 1, 1, '0, 1);
    send_elem(KIND_CMP, VAL_MIN, '0, 1, 0, '0, 1);
    send_elem(KIND_CMP, VAL_MAX, VAL_MIN, 0, 0, '0, 1);
    for (int unsigned k = KIND_CMP + 1; k <= KIND_CODE_MAX; k++)
      send_elem(3'(k), VAL_MAX, VAL_MIN, 1, 1, VAL_MAX, 1);
    // unused kind inside a compare leaves the verdict alone
    send_elem(KIND_CMP, VAL_MIN, VAL_MAX, 1, 1, '0, 0);
    send_elem(KIND_CODE_MAX, VAL_MAX, VAL_MIN, 1, 1, '0, 1);
    send_elem(KIND_CMP, VAL_ONE, VAL_ONE, 1, 1, '0, 1);

    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 46;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 46;
        end
        default: begin
          send_idle_pct = 12;
          recv_stall_pct <= 12;
        end
      endcase
      target = elems_sent + ITEM_COUNT / PHASE_COUNT;
      while (elems_sent < target) begin
        if ($urandom_range(9) == 0)
          send_elem(3'($urandom_range(KIND_CODE_MAX)), random_q16(), random_q16(),
                    1'($urandom_range(1)), 1'($urandom_range(1)), random_q16(),
                    1'($urandom_range(1)));
        else
          send_vector(3'($urandom_range(KIND_CMP)));
      end
    end

    in_valid_i <= 1'b0;
    recv_stall_pct <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
